// ===== sv/lrutk_pkg.sv =====
// Package for the LRU texture key cache: sizes, field widths, the sequencer
// state type and the control group that the top level sends to every cell.
// Depends on nothing.
package lrutk_pkg;

  localparam int DEF_CAPACITY = 256;
  localparam int DEF_ID_BITS  = 32;

  // Fixed widths of the request and result fields.
  localparam int IMAGE_ID_W = 32;
  localparam int OCC_W      = 9;

  // Stream bus widths, whole bytes.
  localparam int S_TDATA_W = 40;  // 35 bits of fields
  localparam int M_TDATA_W = 48;  // 45 bits of fields

  // Request kinds carried on s_tuser.
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // Control group given to every cell of the chain.
  typedef struct packed {
    logic cmp_en;  // latch the compare result against the request key
    logic clear;   // drop the entry
    logic shift;   // take the neighbor's entry
  } cell_ctrl_t;

endpackage

// ===== sv/lrutk_cell.sv =====
// One cell of the recency chain: holds a key and its valid bit, compares it
// against the request key and takes its neighbor's entry when told to shift.
// Depends on lrutk_pkg.
module lrutk_cell #(
  parameter int KEY_W = lrutk_pkg::DEF_ID_BITS + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lrutk_pkg::cell_ctrl_t ctrl,
  input  logic [KEY_W-1:0]      cmp_key,
  input  logic [KEY_W-1:0]      in_key,
  input  logic                  in_valid,
  output logic [KEY_W-1:0]      key,
  output logic                  valid,
  output logic                  match
);
  import lrutk_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctrl.cmp_en) begin
        match <= valid && (key == cmp_key);
      end
      if (ctrl.clear) begin
        valid <= 1'b0;
      end else if (ctrl.shift) begin
        valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!ctrl.clear && ctrl.shift) begin
      key <= in_key;
    end
  end

endmodule

// ===== sv/lrutk_scan.sv =====
// Suffix OR over the match bits of the chain: bit i is set when some cell at
// position i or further down matched. Built as a log-depth prefix network.
// Depends on nothing outside this file.
module lrutk_scan #(
  parameter int N = 256
) (
  input  logic [N-1:0] match,
  output logic [N-1:0] below
);
  localparam int LEVELS = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0] lvl [0:LEVELS];

  assign lvl[0] = match;

  for (genvar k = 0; k < LEVELS; k++) begin : g_level
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i + (1 << k) < N) begin : g_or
        assign lvl[k+1][i] = lvl[k][i] | lvl[k][i + (1 << k)];
      end else begin : g_pass
        assign lvl[k+1][i] = lvl[k][i];
      end
    end
  end

  assign below = lvl[LEVELS];

endmodule

// ===== sv/lru_texture_key_cache.sv =====
// Top level of the LRU texture key cache: request and result stream ports,
// the sequencer, the chain of key cells and the result register.
// Depends on lrutk_pkg, lrutk_cell and lrutk_scan.
//
//   Channel  Direction  Handshake          Payload (lowest bit first)
//   s_*      in         s_tvalid/s_tready  tuser: cmd; tdata: args_present,
//                                          image_id, mipmapped, texture_ok
//   m_*      out        m_tvalid/m_tready  tdata: hit, stored, evicted,
//                                          evicted_image_id, evicted_mipmapped,
//                                          occupancy
//
// Each request has a compare step and an update step: at the accepting edge all
// cells compare their key against the request key in parallel, and in the update
// state the chain shifts and the result register loads. The sequencer takes no
// request in the update state, so each update ends before the next request enters.
// Reset clears every valid bit and the count at once; no clearing pass is run.
// The result register lets a new request enter while a result waits; the
// update step of that request holds until the result register is free.
module lru_texture_key_cache #(
  parameter int CAPACITY = lrutk_pkg::DEF_CAPACITY,
  parameter int ID_BITS  = lrutk_pkg::DEF_ID_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [0] args_present, [32:1] image_id, [33] mipmapped, [34] texture_ok
  input  logic [lrutk_pkg::S_TDATA_W-1:0]  s_tdata,
  // [0] cmd
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] hit, [1] stored, [2] evicted, [34:3] evicted_image_id,
  // [35] evicted_mipmapped, [44:36] occupancy
  output logic [lrutk_pkg::M_TDATA_W-1:0]  m_tdata
);
  import lrutk_pkg::*;

  localparam int KEY_W = ID_BITS + 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Request fields as they arrive on the slave side.
  logic                  in_cmd;
  logic                  in_args;
  logic [IMAGE_ID_W-1:0] in_image_id;
  logic                  in_mip;
  logic                  in_tex_ok;
  logic [KEY_W-1:0]      in_key;

  assign in_cmd      = s_tuser;
  assign in_args     = s_tdata[0];
  assign in_image_id = s_tdata[32:1];
  assign in_mip      = s_tdata[33];
  assign in_tex_ok   = s_tdata[34];
  // The key is the identifier, cut or extended to ID_BITS, with the mipmap bit
  // appended as its lowest bit.
  assign in_key      = {ID_BITS'(in_image_id), in_mip};

  // Sequencer.
  state_t state, state_next;
  logic   accept;
  logic   do_update;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == ST_IDLE);
    accept    = s_tvalid && (state == ST_IDLE);
    do_update = (state == ST_UPDATE) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The request is held here between its compare and its update.
  logic             req_cmd;
  logic             req_args;
  logic             req_tex_ok;
  logic [KEY_W-1:0] req_key;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd    <= in_cmd;
      req_args   <= in_args;
      req_tex_ok <= in_tex_ok;
      req_key    <= in_key;
    end
  end

  // Chain of cells. Cell 0 holds the most recent key, and the valid entries
  // always sit in a run from cell 0, so a cell's position is its recency rank.
  logic [KEY_W-1:0] cell_key   [CAPACITY];
  logic             cell_valid [CAPACITY];
  logic [CAPACITY-1:0] cell_match;
  logic [CAPACITY-1:0] below;

  lrutk_scan #(
    .N (CAPACITY)
  ) u_scan (
    .match (cell_match),
    .below (below)
  );

  logic hit;
  logic do_clear;
  logic do_hit;
  logic do_insert;

  // A hit anywhere shows up at the head of the suffix OR.
  assign hit       = below[0];
  assign do_clear  = do_update && (req_cmd == CMD_CLEAR);
  assign do_hit    = do_update && (req_cmd == CMD_LOOKUP) && req_args && hit;
  assign do_insert = do_update && (req_cmd == CMD_LOOKUP) && req_args && !hit && req_tex_ok;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctrl_t       ctrl;
    logic [KEY_W-1:0] feed_key;
    logic             feed_valid;

    // On a hit only the cells down to the matching one move, which lifts the
    // matching key to the front; on an insert the whole chain moves and the
    // last entry falls off.
    always_comb begin
      ctrl.cmp_en = accept;
      ctrl.clear  = do_clear;
      ctrl.shift  = do_insert || (do_hit && below[i]);
    end

    if (i == 0) begin : g_head
      assign feed_key   = req_key;
      assign feed_valid = 1'b1;
    end else begin : g_link
      assign feed_key   = cell_key[i-1];
      assign feed_valid = cell_valid[i-1];
    end

    lrutk_cell #(
      .KEY_W (KEY_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .cmp_key  (in_key),
      .in_key   (feed_key),
      .in_valid (feed_valid),
      .key      (cell_key[i]),
      .valid    (cell_valid[i]),
      .match    (cell_match[i])
    );
  end

  // Entry count. The chain is full exactly when the count reaches capacity.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             full;

  assign full = (count == CNT_W'(CAPACITY));

  always_comb begin
    count_next = count;
    if (do_clear) begin
      count_next = '0;
    end else if (do_insert && !full) begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result register. An insert into a full chain pushes out the last cell,
  // which then holds the least recent key.
  logic                  evicted;
  logic [ID_BITS-1:0]    last_id;
  logic                  res_hit;
  logic                  res_stored;
  logic                  res_evicted;
  logic [IMAGE_ID_W-1:0] res_ev_id;
  logic                  res_ev_mip;
  logic [OCC_W-1:0]      res_occ;

  assign evicted = do_insert && full;
  assign last_id = cell_key[CAPACITY-1][KEY_W-1:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (do_update) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      res_hit     <= do_hit;
      res_stored  <= do_insert;
      res_evicted <= evicted;
      res_ev_id   <= evicted ? IMAGE_ID_W'(last_id) : '0;
      res_ev_mip  <= evicted ? cell_key[CAPACITY-1][0] : 1'b0;
      res_occ     <= OCC_W'(count_next);
    end
  end

  assign m_tdata = {(M_TDATA_W - 45)'(0), res_occ, res_ev_mip, res_ev_id,
                    res_evicted, res_stored, res_hit};

endmodule
